// ===== design/mailbox_ring_deque_macros.svh =====
// assertion macros for the mailbox ring deque
// expects i_clk and i_rst_n in the scope of use
`ifndef MAILBOX_RING_DEQUE_MACROS_SVH
`define MAILBOX_RING_DEQUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrd_pkg.sv =====
// shared types and constants for the mailbox ring deque
// no dependencies
package mrd_pkg;

    localparam int MRD_DEPTH = 16;
    localparam int CAP_W     = 5;
    localparam int MSG_W     = 32;
    localparam int FILL_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        OP_SEND_BACK  = 2'd0,
        OP_SEND_FRONT = 2'd1,
        OP_GET        = 2'd2,
        OP_FLUSH      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op              opcode;
        logic [MSG_W-1:0] message_in;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [MSG_W-1:0]  message_out;
        logic [FILL_W-1:0] fill_count;
    } t_out_word;

endpackage

// ===== design/mailbox_ring_deque.sv =====
// mailbox ring deque top level: slot memory, pointers, count and result pipeline
// depends on mrd_pkg and mailbox_ring_deque_macros.svh
//
// One operation (send to back, send to front, get, flush) is taken per cycle on
// the input channel unless o_in_stall is high, and each produces exactly one
// result word, via the stage-1 and output registers. Pointers and count update at
// the accepting edge; the slot memory has a single registered read port addressed
// by the read pointer, and its read data joins the result one stage later.
// Capacity must be written on the configuration port while the block is idle;
// the block does not enforce it. Zero acts as one, values above DEPTH as DEPTH.
// Slot contents are undefined until written: no clearing pass.
`include "mailbox_ring_deque_macros.svh"

module mailbox_ring_deque #(
    parameter int DEPTH = mrd_pkg::MRD_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [mrd_pkg::CAP_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  mrd_pkg::t_in_word        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output mrd_pkg::t_out_word       o_out_data
);
    import mrd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [MSG_W-1:0] r_slots [DEPTH];
    logic [MSG_W-1:0] r_rd;

    logic [CAP_W-1:0] r_capacity;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_held, n_held;

    logic              r_s1_v;
    t_status           r_s1_status, n_s1_status;
    logic              r_s1_take, n_s1_take;
    logic [FILL_W-1:0] r_s1_fill;

    logic      r_out_v;
    t_out_word r_out;

    logic             accept;
    logic             advance;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [CMP_W-1:0] cap_raw;
    logic [CMP_W-1:0] cap_sat;
    logic [CNT_W-1:0] cap;
    logic             full;
    logic [CNT_W-1:0] head_inc;
    logic [CNT_W-1:0] tail_inc;
    logic [PTR_W-1:0] head_fwd;
    logic [PTR_W-1:0] head_back;
    logic [PTR_W-1:0] tail_fwd;

    assign advance     = !r_out_v || !i_out_stall;
    assign o_in_stall  = r_s1_v && !advance;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // effective capacity
    always_comb begin
        cap_raw = CMP_W'(r_capacity);
        if (cap_raw == '0) begin
            cap_sat = CMP_W'(1);
        end else if (cap_raw > CMP_W'(DEPTH)) begin
            cap_sat = CMP_W'(DEPTH);
        end else begin
            cap_sat = cap_raw;
        end
        cap = CNT_W'(cap_sat);
    end

    assign full      = r_held >= cap;
    assign head_inc  = CNT_W'(r_head) + CNT_W'(1);
    assign tail_inc  = CNT_W'(r_tail) + CNT_W'(1);
    assign head_fwd  = (head_inc >= cap) ? '0 : PTR_W'(head_inc);
    assign tail_fwd  = (tail_inc >= cap) ? '0 : PTR_W'(tail_inc);
    assign head_back = (r_head == '0) ? PTR_W'(cap - CNT_W'(1)) : r_head - PTR_W'(1);

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_s1_status = ST_OK;
        n_s1_take   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        case (i_in_data.opcode)
            OP_SEND_BACK: begin
                if (full) begin
                    n_s1_status = ST_FULL;
                end else begin
                    wr_en  = 1'b1;
                    n_tail = tail_fwd;
                    n_held = r_held + CNT_W'(1);
                end
            end
            OP_SEND_FRONT: begin
                if (full) begin
                    n_s1_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = head_back;
                    n_head  = head_back;
                    n_held  = r_held + CNT_W'(1);
                end
            end
            OP_GET: begin
                if (r_held == '0) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    n_s1_take = 1'b1;
                    n_head    = head_fwd;
                    n_held    = r_held - CNT_W'(1);
                end
            end
            default: begin
                n_head = '0;
                n_tail = '0;
                n_held = '0;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_slots[wr_addr] <= i_in_data.message_in;
        end
        if (accept) begin
            r_rd <= r_slots[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_head     <= '0;
            r_tail     <= '0;
            r_held     <= '0;
            r_s1_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            if (accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_held <= n_held;
            end
            if (advance) begin
                r_out_v <= r_s1_v;
            end
            if (advance || !r_s1_v) begin
                r_s1_v <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_s1_status;
            r_s1_take   <= n_s1_take;
            r_s1_fill   <= FILL_W'(n_held);
        end
        if (advance && r_s1_v) begin
            r_out.status      <= r_s1_status;
            r_out.message_out <= r_s1_take ? r_rd : '0;
            r_out.fill_count  <= r_s1_fill;
        end
    end

    `MRD_ASSERT_NOW(a_held_bound, 1'b1, r_held <= CNT_W'(DEPTH), "count above depth")
    `MRD_ASSERT_NEXT(a_flush_clears, accept && i_in_data.opcode == OP_FLUSH, r_held == '0 && r_head == '0 && r_tail == '0, "flush did not clear")
    `MRD_ASSERT_NOW(a_empty_fill, r_out_v && r_out.status == ST_EMPTY, r_out.fill_count == '0 && r_out.message_out == '0, "empty result with data")
    `MRD_ASSERT_NOW(a_stall_full, o_in_stall, r_s1_v && r_out_v && i_out_stall, "input stalled with room")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for mailbox_ring_deque: directed, random and back-pressure tests
// keeps its own copy of the ring, pointers and count; depends on mrd_pkg and the block only
module testbench;
    import mrd_pkg::*;

    localparam int unsigned LONG_HOLD      = 80;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_WORDS    = 80;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [CAP_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    t_in_word           i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_cfg_ready;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_word          o_out_data;

    // own copy of the mailbox
    logic [MSG_W-1:0]   slot_copy [MRD_DEPTH];
    bit                 slot_loaded [MRD_DEPTH];
    int unsigned        rd_ptr;
    int unsigned        wr_ptr;
    int unsigned        held_count;
    logic [CAP_W-1:0]   capacity_reg;
    t_out_word          pending_results [$];

    int unsigned        error_count;
    int unsigned        ops_sent;
    int unsigned        words_checked;
    int unsigned        full_seen;
    int unsigned        empty_seen;
    int unsigned        cap_writes;
    int unsigned        idle_cycles;
    int unsigned        rx_burst;
    bit                 tx_gaps;
    bit                 rx_gaps;
    bit                 hold_req;

    mailbox_ring_deque u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned usable_slots();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > MRD_DEPTH) return MRD_DEPTH;
        return capacity_reg;
    endfunction

    function automatic t_out_word mailbox_apply(t_in_word w);
        t_out_word   r;
        int unsigned cap;
        cap = usable_slots();
        r.status = ST_OK;
        r.message_out = '0;
        case (w.opcode)
            OP_SEND_BACK, OP_SEND_FRONT: begin
                if (held_count >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    if (w.opcode == OP_SEND_FRONT) begin
                        rd_ptr = (rd_ptr == 0) ? cap - 1 : rd_ptr - 1;
                        slot_copy[rd_ptr] = w.message_in;
                        slot_loaded[rd_ptr] = 1'b1;
                    end else begin
                        slot_copy[wr_ptr] = w.message_in;
                        slot_loaded[wr_ptr] = 1'b1;
                        wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
                    end
                    held_count++;
                end
            end
            OP_GET: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    held_count--;
                    r.message_out = slot_copy[rd_ptr];
                    rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
                end
            end
            default: begin
                rd_ptr = 0;
                wr_ptr = 0;
                held_count = 0;
            end
        endcase
        r.fill_count = FILL_W'(held_count);
        return r;
    endfunction

    function automatic int unsigned gap_cycles();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [MSG_W-1:0] rand_message();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_op pick_op(int unsigned send_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_FLUSH;
        if (r < 3 + send_pct) return $urandom_range(0, 1) ? OP_SEND_FRONT : OP_SEND_BACK;
        return OP_GET;
    endfunction

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= 10) $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic issue_op(input t_op op, input logic [MSG_W-1:0] msg);
        t_in_word    w;
        int unsigned n;
        // a get must never land on a slot that was never written
        if (op == OP_GET && held_count != 0 && !slot_loaded[rd_ptr]) op = OP_FLUSH;
        w.opcode = op;
        w.message_in = msg;
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(mailbox_apply(w));
        ops_sent++;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            n = gap_cycles();
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity_reg = value;
        cap_writes++;
    endtask

    task automatic test_reset_order();
        issue_op(OP_GET, '0);
        issue_op(OP_FLUSH, 32'h1234_5678);
        issue_op(OP_SEND_BACK, '1);
        issue_op(OP_SEND_BACK, '0);
        issue_op(OP_SEND_FRONT, 32'hA5A5_A5A5);
        issue_op(OP_GET, '0);
        issue_op(OP_GET, '0);
        issue_op(OP_GET, '0);
        issue_op(OP_GET, '0);
    endtask

    task automatic test_capacity_extremes();
        write_capacity(CAP_W'(1));
        issue_op(OP_SEND_BACK, 32'h0000_0001);
        issue_op(OP_SEND_BACK, 32'h8000_0000);
        issue_op(OP_SEND_FRONT, 32'h5A5A_5A5A);
        issue_op(OP_GET, '0);
        issue_op(OP_SEND_FRONT, 32'hFFFF_0000);
        issue_op(OP_GET, '0);
        issue_op(OP_FLUSH, '0);
        write_capacity(CAP_W'(0));
        issue_op(OP_SEND_BACK, 32'h0000_FFFF);
        issue_op(OP_SEND_BACK, '1);
        issue_op(OP_GET, '0);
        write_capacity(CAP_W'(31));
        issue_op(OP_SEND_FRONT, 32'hC3C3_C3C3);
        issue_op(OP_GET, '0);
    endtask

    task automatic test_random_traffic();
        int unsigned      phase;
        int unsigned      k;
        int unsigned      send_pct;
        logic [CAP_W-1:0] cap;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 5)
                0: cap = CAP_W'($urandom_range(1, 4));
                1: cap = CAP_W'(MRD_DEPTH);
                2: cap = CAP_W'($urandom_range(0, 31));
                3: cap = CAP_W'($urandom_range(17, 31));
                default: cap = CAP_W'($urandom_range(2, 15));
            endcase
            // messages are left in place across most capacity changes
            if ($urandom_range(0, 3) == 0) issue_op(OP_FLUSH, rand_message());
            write_capacity(cap);
            tx_gaps = (phase != 3);
            rx_gaps = (phase != 3 && phase != 7);
            case (phase % 3)
                0: send_pct = 75;
                1: send_pct = 50;
                default: send_pct = 30;
            endcase
            for (k = 0; k < PHASE_WORDS; k++) issue_op(pick_op(send_pct), rand_message());
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        int unsigned k;
        write_capacity(CAP_W'(MRD_DEPTH));
        tx_gaps = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 30; k++) issue_op(pick_op(60), rand_message());
        // sender holds off until every result is back
        wait_drained();
        for (k = 0; k < 10; k++) issue_op(pick_op(50), rand_message());
        tx_gaps = 1'b1;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_checked++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("result word %h with nothing expected", o_out_data));
            end else begin
                want = pending_results.pop_front();
                if (want.status == ST_FULL) full_seen++;
                if (want.status == ST_EMPTY) empty_seen++;
                if (o_out_data.status !== want.status)
                    note_error($sformatf("status exp %0d got %0d", want.status,
                                         o_out_data.status));
                if (o_out_data.message_out !== want.message_out)
                    note_error($sformatf("message exp %h got %h", want.message_out,
                                         o_out_data.message_out));
                if (o_out_data.fill_count !== want.fill_count)
                    note_error($sformatf("fill exp %0d got %0d", want.fill_count,
                                         o_out_data.fill_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_burst != 0) begin
            rx_burst <= rx_burst - 1;
        end else if (hold_req) begin
            i_out_stall <= 1'b1;
            rx_burst <= LONG_HOLD;
            hold_req = 1'b0;
        end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            rx_burst <= gap_cycles() - 1;
        end else begin
            i_out_stall <= 1'b0;
            rx_burst <= rx_gaps ? $urandom_range(0, 5) : 0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mailbox_ring_deque regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rd_ptr = 0;
        wr_ptr = 0;
        held_count = 0;
        capacity_reg = CAP_RESET;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        hold_req = 1'b0;
        rx_burst = 0;
        idle_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_order();
        test_capacity_extremes();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("%0d operations sent, %0d result words checked, %0d capacity writes",
                 ops_sent, words_checked, cap_writes);
        $display("%0d full and %0d empty outcomes, %0d mismatches",
                 full_seen, empty_seen, error_count);
        if (error_count == 0) begin
            $display("mailbox_ring_deque regression: pass");
        end else begin
            $display("mailbox_ring_deque regression: fail");
        end
        $finish;
    end

endmodule
